>>> rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg: shared types and defaults for the point-in-polygon test unit
// Holds the default coordinate width, the edge queue depth, the flags that
// travel with each edge beat and the front-end state encoding.
// ----------------------------------------------------------------------------
package pip_pkg;

   // default coordinate width (signed fixed point)
   localparam int COORD_WIDTH_DEF = 16;

   // entries in the edge queue between front and back
   localparam int QUEUE_DEPTH_DEF = 4;

   // control flags carried with each edge beat
   typedef struct packed {
      logic clear;   // first edge of a polygon: start parity from zero
      logic emit;    // closing edge: deliver the parity as a result
   } pip_flags_type;

   // front-end sequencer, one-hot
   typedef enum logic [1:0] {
      ST_TAKE  = 2'b01,
      ST_CLOSE = 2'b10
   } pip_state_type;

endpackage

>>> rtl/point_in_polygon_test_unit.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit: even-odd ray-crossing point-in-polygon test
// Streams polygon vertices, tests every edge against the query point and
// returns one inside/outside bit per polygon.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------
//   req     | in        | req_valid/stall    | point y/x, vertex y/x, last mark
//   rsp     | out       | rsp_valid/stall    | inside_res
//
// A vertex beat queues one edge; a beat with the last mark also queues the
// closing edge, and req_stall stays high until the front end has done so.
// A result follows its closing edge from the queue through the difference,
// product and compare stages of the back end.
// Reset is synchronous and active high; it empties the queue and pipeline.
// A stalled result freezes the back end; the queue then fills and req_stall
// rises once it is full.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit import pip_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_y,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_x,
   input  logic                          req_last_vertex,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_inside_res
);

   localparam int EW = 6 * COORD_WIDTH;
   localparam int QW = EW + $bits(pip_flags_type);

   logic          push, pop, queue_full, head_valid;
   logic [EW-1:0] push_edge, head_edge;
   pip_flags_type push_flags, head_flags;
   logic [QW-1:0] head_data;

   pip_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_point_y     (req_point_y),
      .req_point_x     (req_point_x),
      .req_vertex_y    (req_vertex_y),
      .req_vertex_x    (req_vertex_x),
      .req_last_vertex (req_last_vertex),
      .push            (push),
      .push_edge       (push_edge),
      .push_flags      (push_flags),
      .queue_full      (queue_full)
   );

   pip_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_edge, push_flags}),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (head_valid),
      .head_data (head_data)
   );

   assign {head_edge, head_flags} = head_data;

   pip_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_edge      (head_edge),
      .head_flags     (head_flags),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_inside_res (rsp_inside_res)
   );

endmodule

>>> rtl/pip_queue.sv
// ----------------------------------------------------------------------------
// pip_queue: short edge queue
// Small circular buffer that decouples the vertex front end from the
// crossing-test back end.
// ----------------------------------------------------------------------------
module pip_queue import pip_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] head_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = mem_ff[rd_ptr_ff];

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the incoming beat
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/pip_front.sv
// ----------------------------------------------------------------------------
// pip_front: vertex front end
// Accepts vertex beats, latches the query point and first vertex, and turns
// each beat into an edge for the back end; a last vertex adds the closing edge.
// ----------------------------------------------------------------------------
module pip_front import pip_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_y,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_x,
   input  logic                          req_last_vertex,
   output logic                          push,
   output logic [6*COORD_WIDTH-1:0]      push_edge,
   output pip_flags_type                 push_flags,
   input  logic                          queue_full
);

   localparam int W = COORD_WIDTH;

   pip_state_type state_ff, state_in;
   logic          in_poly_ff, in_poly_in;
   logic          take;

   logic signed [W-1:0] query_y_ff, query_x_ff;
   logic signed [W-1:0] first_y_ff, first_x_ff;
   logic signed [W-1:0] prev_y_ff,  prev_x_ff;

   assign req_stall = (state_ff != ST_TAKE) || queue_full;
   assign take      = req_valid && !req_stall;

   // build the edge beat: {query y, query x, vertex i y, x, vertex j y, x}
   always_comb begin
      push       = 1'b0;
      push_edge  = {query_y_ff, query_x_ff, first_y_ff, first_x_ff, prev_y_ff, prev_x_ff};
      push_flags = '{clear: 1'b0, emit: 1'b0};
      state_in   = state_ff;
      in_poly_in = in_poly_ff;
      case (state_ff)
         ST_TAKE: begin
            if (take) begin
               push       = 1'b1;
               in_poly_in = !req_last_vertex;
               if (req_last_vertex) begin
                  state_in = ST_CLOSE;
               end
               if (!in_poly_ff) begin
                  // first vertex: degenerate edge, restart parity
                  push_edge  = {req_point_y, req_point_x, req_vertex_y, req_vertex_x,
                                req_vertex_y, req_vertex_x};
                  push_flags = '{clear: 1'b1, emit: 1'b0};
               end else begin
                  push_edge  = {query_y_ff, query_x_ff, req_vertex_y, req_vertex_x,
                                prev_y_ff, prev_x_ff};
               end
            end
         end
         ST_CLOSE: begin
            // closing edge from first vertex to the last one, then report
            if (!queue_full) begin
               push       = 1'b1;
               push_flags = '{clear: 1'b0, emit: 1'b1};
               state_in   = ST_TAKE;
            end
         end
         default: begin
            state_in = ST_TAKE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_TAKE;
         in_poly_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         in_poly_ff <= in_poly_in;
      end
   end

   // hold the polygon context
   always_ff @(posedge clock) begin
      if (take) begin
         prev_y_ff <= req_vertex_y;
         prev_x_ff <= req_vertex_x;
         if (!in_poly_ff) begin
            query_y_ff <= req_point_y;
            query_x_ff <= req_point_x;
            first_y_ff <= req_vertex_y;
            first_x_ff <= req_vertex_x;
         end
      end
   end

endmodule

>>> rtl/pip_back.sv
// ----------------------------------------------------------------------------
// pip_back: crossing-test back end
// Three-stage pipeline: differences, cross products, compare and parity.
// Delivers the parity on a closing edge through the result register.
// ----------------------------------------------------------------------------
module pip_back import pip_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  logic [6*COORD_WIDTH-1:0] head_edge,
   input  pip_flags_type            head_flags,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_inside_res
);

   localparam int W  = COORD_WIDTH;
   localparam int DW = W + 1;
   localparam int PW = 2 * DW;

   logic signed [W-1:0] qy, qx, yi, xi, yj, xj;
   logic                adv;

   // difference stage
   logic                 a_valid_ff;
   pip_flags_type        a_flags_ff;
   logic                 a_straddle_ff;
   logic signed [DW-1:0] a_d_ff, a_ax_ff, a_bx_ff, a_cy_ff;

   // product stage
   logic                 b_valid_ff;
   pip_flags_type        b_flags_ff;
   logic                 b_straddle_ff;
   logic                 b_dpos_ff;
   logic signed [PW-1:0] b_l_ff, b_r_ff;

   // parity and result
   logic parity_ff, parity_in;
   logic hit;
   logic rsp_valid_ff;
   logic rsp_inside_ff;

   assign {qy, qx, yi, xi, yj, xj} = head_edge;

   // the whole pipeline holds while a result waits
   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         parity_ff    <= 1'b0;
      end else if (adv) begin
         a_valid_ff   <= head_valid;
         b_valid_ff   <= a_valid_ff;
         rsp_valid_ff <= b_valid_ff && b_flags_ff.emit;
         if (b_valid_ff) begin
            parity_ff <= parity_in;
         end
      end
   end

   // take differences of the edge against the query point
   always_ff @(posedge clock) begin
      if (adv) begin
         a_flags_ff    <= head_flags;
         a_straddle_ff <= (yi > qy) != (yj > qy);
         a_d_ff        <= DW'(yj) - DW'(yi);
         a_ax_ff       <= DW'(qx) - DW'(xi);
         a_bx_ff       <= DW'(xj) - DW'(xi);
         a_cy_ff       <= DW'(qy) - DW'(yi);
      end
   end

   // form both cross products
   always_ff @(posedge clock) begin
      if (adv) begin
         b_flags_ff    <= a_flags_ff;
         b_straddle_ff <= a_straddle_ff;
         b_dpos_ff     <= (a_d_ff > 0);
         b_l_ff        <= PW'(a_ax_ff) * PW'(a_d_ff);
         b_r_ff        <= PW'(a_bx_ff) * PW'(a_cy_ff);
      end
   end

   // compare with the sign of the y difference and toggle parity
   always_comb begin
      if (b_dpos_ff) begin
         hit = b_straddle_ff && (b_l_ff < b_r_ff);
      end else begin
         hit = b_straddle_ff && (b_r_ff < b_l_ff);
      end
      parity_in = (b_flags_ff.clear ? 1'b0 : parity_ff) ^ hit;
   end

   always_ff @(posedge clock) begin
      if (adv && b_valid_ff && b_flags_ff.emit) begin
         rsp_inside_ff <= parity_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

endmodule

>>> rtl/pip_checker.sv
// ----------------------------------------------------------------------------
// pip_checker: port-level checks for the point-in-polygon test unit
// Watches the top-level ports only and is bound to the top level.
// ----------------------------------------------------------------------------
module pip_checker import pip_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_last_vertex,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_inside_res
);

   logic       req_beat, rsp_beat, last_beat;
   logic [7:0] pending_ff, pending_in;

   assign req_beat  = req_valid && !req_stall;
   assign rsp_beat  = rsp_valid && !rsp_stall;
   assign last_beat = req_beat && req_last_vertex;

   // count polygons closed but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (last_beat && !rsp_beat) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_beat && !last_beat) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // no result beat without a closed polygon behind it
   a_no_orphan_result: assert property (@(posedge clock) disable iff (reset)
      rsp_beat |-> (pending_ff != '0))
      else $error("result beat without a closed polygon");

   // closing edge occupies the front end for the following cycle
   a_close_stalls: assert property (@(posedge clock) disable iff (reset)
      last_beat |=> req_stall)
      else $error("front end took a beat during the closing edge");

   // reset leaves no result pending
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_inside_res)))
      else $error("stalled result changed");

endmodule

bind point_in_polygon_test_unit pip_checker u_pip_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_last_vertex (req_last_vertex),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_inside_res  (rsp_inside_res)
);

>>> tb/point_in_polygon_test_unit_tb.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit_tb: self-checking bench for the crossing test
// Streams polygons into the unit. A directed set covers degenerate polygons,
// extreme coordinates and points on vertices and edges. Random polygons
// follow, drawn near the query point, across the full range or from corner
// values. A behavioral even-odd predictor computes each inside bit not typed
// into a directed row. Random idle and stall bursts run on both channels.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit_tb;
   import pip_pkg::*;

   localparam int CW           = COORD_WIDTH_DEF;
   localparam int RANDOM_BEATS = 1500;
   localparam int QUIET_FROM   = 1300;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 200000;

   typedef logic signed [CW-1:0] coord_type;

   localparam coord_type MIN_C = {1'b1, {(CW-1){1'b0}}};
   localparam coord_type MAX_C = {1'b0, {(CW-1){1'b1}}};

   // one vertex beat; known marks a row whose inside bit is typed in
   typedef struct {
      coord_type py, px, vy, vx;
      logic      last;
      logic      known;
      logic      want_in;
   } vertex_beat_type;

   logic      clock           = 1'b0;
   logic      reset           = 1'b1;
   logic      req_valid       = 1'b0;
   logic      req_stall;
   coord_type req_point_y     = '0;
   coord_type req_point_x     = '0;
   coord_type req_vertex_y    = '0;
   coord_type req_vertex_x    = '0;
   logic      req_last_vertex = 1'b0;
   logic      rsp_valid;
   logic      rsp_stall       = 1'b0;
   logic      rsp_inside_res;

   // predictor state
   coord_type first_y, first_x, prev_y, prev_x, query_y, query_x;
   logic      parity;
   logic      in_polygon;

   logic            inside_bits_q[$];
   vertex_beat_type vectors[$];
   int              fail_count  = 0;
   int              beats_sent  = 0;
   int              results_in  = 0;
   int              cycle_count = 0;
   bit              idle_on     = 1'b1;

   point_in_polygon_test_unit #(.COORD_WIDTH(CW)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_point_y     (req_point_y),
      .req_point_x     (req_point_x),
      .req_vertex_y    (req_vertex_y),
      .req_vertex_x    (req_vertex_x),
      .req_last_vertex (req_last_vertex),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_inside_res  (rsp_inside_res)
   );

   always #10 clock = ~clock;

   // hard stop on a hang
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic report_mismatch(string what, logic got, logic want);
      $display("MISMATCH result %0d: %s (got %b, want %b)", results_in, what, got, want);
      fail_count++;
   endtask

   // does edge i->j cross the ray going right from the query point
   function automatic bit ray_crosses(coord_type yi, coord_type xi,
                                      coord_type yj, coord_type xj);
      longint d, lhs, rhs;
      if ((yi > query_y) == (yj > query_y))
         return 1'b0;
      d   = longint'(yj) - longint'(yi);
      lhs = (longint'(query_x) - longint'(xi)) * d;
      rhs = (longint'(xj) - longint'(xi)) * (longint'(query_y) - longint'(yi));
      return (d > 0) ? (lhs < rhs) : (rhs < lhs);
   endfunction

   // advance the predictor by one accepted beat
   task automatic track_vertex(vertex_beat_type b);
      if (!in_polygon) begin
         query_y    = b.py;
         query_x    = b.px;
         first_y    = b.vy;
         first_x    = b.vx;
         parity     = 1'b0;
         in_polygon = 1'b1;
      end else if (ray_crosses(b.vy, b.vx, prev_y, prev_x)) begin
         parity = ~parity;
      end
      prev_y = b.vy;
      prev_x = b.vx;
      if (b.last) begin
         if (ray_crosses(first_y, first_x, b.vy, b.vx))
            parity = ~parity;
         inside_bits_q.push_back(b.known ? b.want_in : parity);
         in_polygon = 1'b0;
      end
   endtask

   // drive one beat at the falling edge, hold it until accepted
   task automatic send_beat(vertex_beat_type b);
      idle_on = (beats_sent < QUIET_FROM) && ((beats_sent / 200) % 3 != 2);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_point_y     <= b.py;
      req_point_x     <= b.px;
      req_vertex_y    <= b.vy;
      req_vertex_x    <= b.vx;
      req_last_vertex <= b.last;
      do @(posedge clock); while (req_stall);
      track_vertex(b);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic add_row(coord_type py, coord_type px, coord_type vy, coord_type vx,
                          logic last, logic known, logic want_in);
      vertex_beat_type b;
      b.py = py; b.px = px; b.vy = vy; b.vx = vx;
      b.last = last; b.known = known; b.want_in = want_in;
      vectors.push_back(b);
   endtask

   function automatic coord_type corner_coord();
      case ($urandom_range(0, 4))
         0:       return MIN_C;
         1:       return MAX_C;
         2:       return '0;
         3:       return '1;
         default: return coord_type'(1);
      endcase
   endfunction

   // vertex coordinate: full range, tight or wide box around the point, corners
   function automatic coord_type pick_coord(int mode, coord_type center);
      int off;
      case (mode)
         0: return coord_type'($urandom);
         1: begin
            off = int'($urandom_range(0, 16)) - 8;
            return coord_type'(int'(center) + off);
         end
         2: return corner_coord();
         default: begin
            off = int'($urandom_range(0, 600)) - 300;
            return coord_type'(int'(center) + off);
         end
      endcase
   endfunction

   task automatic send_random_polygon();
      int              n, mode, k;
      coord_type       cy, cx;
      vertex_beat_type b;
      n    = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      mode = $urandom_range(0, 3);
      cy   = (mode == 2) ? corner_coord() : coord_type'($urandom);
      cx   = (mode == 2) ? corner_coord() : coord_type'($urandom);
      for (k = 0; k < n; k++) begin
         // point fields past the first beat are noise
         b.py      = (k == 0) ? cy : coord_type'($urandom);
         b.px      = (k == 0) ? cx : coord_type'($urandom);
         b.vy      = pick_coord(mode, cy);
         b.vx      = pick_coord(mode, cx);
         b.last    = (k == n - 1);
         b.known   = 1'b0;
         b.want_in = 1'b0;
         send_beat(b);
      end
   endtask

   // drive result stall in random bursts
   initial begin
      int left;
      left = 0;
      forever begin
         @(negedge clock);
         if (left > 0)
            left--;
         else if (idle_on && $urandom_range(0, 5) == 0)
            left = $urandom_range(1, 4);
         rsp_stall <= (left > 0);
      end
   end

   // check each accepted result beat against the oldest prediction
   always @(posedge clock) begin : check_results
      logic want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (inside_bits_q.size() == 0) begin
            report_mismatch("result beat with nothing outstanding", rsp_inside_res, 1'bx);
         end else begin
            want = inside_bits_q.pop_front();
            if (rsp_inside_res !== want)
               report_mismatch("inside_res", rsp_inside_res, want);
         end
         results_in++;
      end
   end

   initial begin
      in_polygon = 1'b0;
      parity     = 1'b0;
      first_y = '0; first_x = '0; prev_y = '0; prev_x = '0;
      query_y = '0; query_x = '0;

      // single vertex: degenerate closing edge
      add_row(0, 0, 5, 5, 1, 1, 0);
      // two vertices: crossings cancel
      add_row(0, 0, -10, -10, 0, 0, 0);
      add_row(0, 0, 10, 10, 1, 1, 0);
      // square around the point
      add_row(0, 0, -100, -100, 0, 0, 0);
      add_row(0, 0, -100, 100, 0, 0, 0);
      add_row(0, 0, 100, 100, 0, 0, 0);
      add_row(0, 0, 100, -100, 1, 1, 1);
      // full-range square, later point fields at the extremes
      add_row(0, 0, MIN_C, MIN_C, 0, 0, 0);
      add_row(MAX_C, MIN_C, MIN_C, MAX_C, 0, 0, 0);
      add_row(MIN_C, MAX_C, MAX_C, MAX_C, 0, 0, 0);
      add_row(MAX_C, MAX_C, MAX_C, MIN_C, 1, 1, 1);
      // point far right of a triangle
      add_row(0, MAX_C, -50, -50, 0, 0, 0);
      add_row(MIN_C, MIN_C, 50, 0, 0, 0, 0);
      add_row(MAX_C, 0, 0, -50, 1, 1, 0);
      // point on a vertex
      add_row(0, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, 10, 10, 0, 0, 0);
      add_row(0, 0, 10, -10, 1, 0, 0);
      // point on the closing edge
      add_row(0, 0, -10, 0, 0, 0, 0);
      add_row(0, 0, -10, 20, 0, 0, 0);
      add_row(0, 0, 10, 20, 0, 0, 0);
      add_row(0, 0, 10, 0, 1, 0, 0);
      // two vertices at opposite corners, point at the minimum
      add_row(MIN_C, MIN_C, MIN_C, MIN_C, 0, 0, 0);
      add_row(-1, -1, MAX_C, MAX_C, 1, 1, 0);

      // hold reset, release at a falling edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (vectors[i])
         send_beat(vectors[i]);
      while (beats_sent < RANDOM_BEATS + vectors.size())
         send_random_polygon();
      req_valid <= 1'b0;

      // drain outstanding results, then let the pipeline settle
      while (inside_bits_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

>>> files.f
rtl/pip_pkg.sv
rtl/pip_queue.sv
rtl/pip_front.sv
rtl/pip_back.sv
rtl/point_in_polygon_test_unit.sv
rtl/pip_checker.sv
tb/point_in_polygon_test_unit_tb.sv
